### rtl/core/bswec_pkg.sv
package bswec_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ADD = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

endpackage

### rtl/core/bounded_set_with_even_count.sv
// channel | ports                                          | direction
// --------+------------------------------------------------+----------
// request | in_valid, in_stall, in_kind, in_value          | in
// result  | out_valid, out_stall, out_was_member,          | out
//         | out_dropped_full, out_member_count, out_even_count |
//
// one request per cycle sustained while out_stall is low; the request register
// feeds a parallel compare over all entries; the set and counts update, and the
// result becomes valid, as the request moves into the result register.
// rst_n clears the counts and both valid flags; entries need no clearing.
// a stalled result holds, and the request register keeps taking a new request
// whenever its content moves on in the same cycle.
module bounded_set_with_even_count #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bswec_pkg::kind_t            in_kind,
  input  bswec_pkg::value_t           in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_was_member,
  output logic                        out_dropped_full,
  output bswec_pkg::count_out_t       out_member_count,
  output bswec_pkg::count_out_t       out_even_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request register
  logic              req_v_r;
  bswec_pkg::kind_t  req_kind_r;
  bswec_pkg::value_t req_value_r;

  // set state
  bswec_pkg::value_t entries_r [CAPACITY];
  logic [CW-1:0]     size_r, size_nxt;
  logic [CW-1:0]     even_r, even_nxt;

  // result register
  logic                  out_v_r;
  logic                  was_member_r;
  logic                  dropped_r;
  bswec_pkg::count_out_t member_count_r;
  bswec_pkg::count_out_t even_count_r;

  logic                  advance;
  logic                  fire;
  logic [CAPACITY-1:0]   hit;
  logic                  member;
  logic                  is_even;
  logic                  full;
  logic                  do_add;
  logic                  do_remove;
  logic                  dropped;
  logic [CW-1:0]         last_cnt;
  logic [IW-1:0]         last_idx;
  logic [IW-1:0]         add_idx;
  bswec_pkg::value_t     last_entry;

  assign advance  = !out_v_r || !out_stall;
  assign fire     = req_v_r && advance;
  assign in_stall = req_v_r && !advance;

  // entries never hold duplicates, so at most one occupied slot matches
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (entries_r[i] == req_value_r) && (CW'(i) < size_r);
    end
  end

  assign member     = |hit;
  assign is_even    = !req_value_r[0];
  assign full       = size_r >= CW'(CAPACITY);
  assign last_cnt   = size_r - CW'(1);
  assign last_idx   = last_cnt[IW-1:0];
  assign add_idx    = size_r[IW-1:0];
  assign last_entry = entries_r[last_idx];

  always_comb begin
    do_add    = 1'b0;
    do_remove = 1'b0;
    dropped   = 1'b0;
    case (req_kind_r)
      bswec_pkg::KIND_ADD: begin
        do_add  = !member && !full;
        dropped = !member && full;
      end
      bswec_pkg::KIND_REMOVE: begin
        do_remove = member && (size_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    size_nxt = size_r;
    even_nxt = even_r;
    if (do_add) begin
      size_nxt = size_r + CW'(1);
      if (is_even) even_nxt = even_r + CW'(1);
    end else if (do_remove) begin
      size_nxt = last_cnt;
      if (is_even && (even_r != '0)) even_nxt = even_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (!in_stall) begin
      req_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind_r  <= in_kind;
      req_value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      even_r <= '0;
    end else if (fire) begin
      size_r <= size_nxt;
      even_r <= even_nxt;
    end
  end

  // swap remove: the matching slot takes the last occupied entry
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_add && (add_idx == IW'(i))) begin
          entries_r[i] <= req_value_r;
        end else if (do_remove && hit[i]) begin
          entries_r[i] <= last_entry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= req_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      was_member_r   <= member;
      dropped_r      <= dropped;
      member_count_r <= bswec_pkg::count_out_t'(size_nxt);
      even_count_r   <= bswec_pkg::count_out_t'(even_nxt);
    end
  end

  assign out_valid        = out_v_r;
  assign out_was_member   = was_member_r;
  assign out_dropped_full = dropped_r;
  assign out_member_count = member_count_r;
  assign out_even_count   = even_count_r;

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CW'(CAPACITY))
    else $error("member count above capacity");

  a_even_bound: assert property (@(posedge clk) disable iff (!rst_n)
    even_r <= size_r)
    else $error("even count above member count");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(size_r) && $stable(even_r))
    else $error("set counts changed without a request moving on");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    fire && dropped |-> !member && (size_r == CW'(CAPACITY)))
    else $error("add dropped while set not full or value present");

endmodule

### verif/tb_top.sv
module tb_top;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned PRESSURE_AT = 600;
  localparam int unsigned PRESSURE_CYCLES = 150;
  localparam bswec_pkg::kind_t KIND_RESERVED = 2'd3;
  localparam bswec_pkg::value_t VALUE_MIN = 32'h8000_0000;
  localparam bswec_pkg::value_t VALUE_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic                  was_member;
    logic                  dropped_full;
    bswec_pkg::count_out_t member_count;
    bswec_pkg::count_out_t even_count;
  } set_result_t;

  class set_scoreboard;
    bswec_pkg::value_t members[CAPACITY];
    int unsigned       size_now;
    int unsigned       evens_now;
    set_result_t       pending_q[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       checked;
    int unsigned       hits;
    int unsigned       drops;
    int unsigned       peak;

    function new();
      size_now = 0;
      evens_now = 0;
      errors = 0;
      requests = 0;
      checked = 0;
      hits = 0;
      drops = 0;
      peak = 0;
    endfunction

    function void note_request(bswec_pkg::kind_t kind, bswec_pkg::value_t value);
      int          slot;
      int unsigned i;
      bit          is_even;
      set_result_t res;
      slot = -1;
      for (i = 0; i < size_now; i++) begin
        if (slot < 0 && members[i] == value) slot = int'(i);
      end
      is_even = ~value[0];
      res.was_member = (slot >= 0);
      res.dropped_full = 1'b0;
      if (kind == bswec_pkg::KIND_ADD && slot < 0) begin
        if (size_now >= CAPACITY) begin
          res.dropped_full = 1'b1;
          drops++;
        end else begin
          members[size_now] = value;
          size_now++;
          if (is_even) evens_now++;
        end
      end else if (kind == bswec_pkg::KIND_REMOVE && slot >= 0) begin
        // last occupied entry fills the hole
        members[slot] = members[size_now-1];
        size_now--;
        if (is_even) evens_now--;
      end
      if (slot >= 0) hits++;
      if (size_now > peak) peak = size_now;
      res.member_count = size_now[bswec_pkg::COUNT_OUT_W-1:0];
      res.even_count = evens_now[bswec_pkg::COUNT_OUT_W-1:0];
      requests++;
      pending_q = {pending_q, res};
    endfunction

    function void check_result(logic was_member, logic dropped_full,
                               bswec_pkg::count_out_t member_count,
                               bswec_pkg::count_out_t even_count);
      set_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: member %0b dropped %0b count %0d even %0d",
                 $time, was_member, dropped_full, member_count, even_count);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (was_member !== want.was_member) begin
        errors++;
        $display("%0t: was_member expected %0b got %0b", $time, want.was_member, was_member);
      end
      if (dropped_full !== want.dropped_full) begin
        errors++;
        $display("%0t: dropped_full expected %0b got %0b", $time, want.dropped_full,
                 dropped_full);
      end
      if (member_count !== want.member_count) begin
        errors++;
        $display("%0t: member_count expected %0d got %0d", $time, want.member_count,
                 member_count);
      end
      if (even_count !== want.even_count) begin
        errors++;
        $display("%0t: even_count expected %0d got %0d", $time, want.even_count, even_count);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  bswec_pkg::kind_t      in_kind = bswec_pkg::KIND_QUERY;
  bswec_pkg::value_t     in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_was_member;
  logic                  out_dropped_full;
  bswec_pkg::count_out_t out_member_count;
  bswec_pkg::count_out_t out_even_count;

  set_scoreboard     sb = new();
  int unsigned       accepted = 0;
  bswec_pkg::value_t value_pool[POOL_SIZE];

  bounded_set_with_even_count #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_was_member(out_was_member),
    .out_dropped_full(out_dropped_full),
    .out_member_count(out_member_count),
    .out_even_count(out_even_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic bswec_pkg::kind_t pick_kind(bit add_heavy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (add_heavy ? 60 : 25)) return bswec_pkg::KIND_ADD;
    else if (r < 80) return bswec_pkg::KIND_REMOVE;
    else if (r < 95) return bswec_pkg::KIND_QUERY;
    else return KIND_RESERVED;
  endfunction

  // small pool so that hits, fills and swaps happen often
  function automatic bswec_pkg::value_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    else if (r < 88) return bswec_pkg::value_t'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return -1;
        2: return VALUE_MIN;
        default: return VALUE_MAX;
      endcase
    end
  endfunction

  task automatic send_request(bswec_pkg::kind_t kind, bswec_pkg::value_t value, bit calm);
    int unsigned gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_kind, in_value);
        accepted++;
      end
      if (out_valid && !out_stall)
        sb.check_result(out_was_member, out_dropped_full, out_member_count, out_even_count);
    end
  end

  // result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int unsigned hold;
    bit          pressure_done;
    pressure_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && accepted >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        hold = gap_len();
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned       n;
    int unsigned       k;
    bswec_pkg::value_t fill_value;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, extremes, duplicates, reserved kind, swap on remove
    send_request(bswec_pkg::KIND_QUERY, '0, 1'b0);
    send_request(bswec_pkg::KIND_REMOVE, -1, 1'b0);
    send_request(bswec_pkg::KIND_ADD, '0, 1'b0);
    send_request(bswec_pkg::KIND_ADD, -1, 1'b0);
    send_request(bswec_pkg::KIND_ADD, VALUE_MAX, 1'b0);
    send_request(bswec_pkg::KIND_ADD, VALUE_MIN, 1'b0);
    send_request(bswec_pkg::KIND_ADD, '0, 1'b0);
    send_request(bswec_pkg::KIND_QUERY, -1, 1'b0);
    send_request(KIND_RESERVED, VALUE_MIN, 1'b0);
    send_request(bswec_pkg::KIND_REMOVE, '0, 1'b0);
    send_request(bswec_pkg::KIND_REMOVE, 1, 1'b0);
    // fill up, then push past capacity
    fill_value = '0;
    for (k = 0; k < CAPACITY - 3; k++) begin
      fill_value = bswec_pkg::value_t'(32'h5a5a_0000 + k);
      if (k[0]) fill_value = -fill_value;
      send_request(bswec_pkg::KIND_ADD, fill_value, 1'b0);
    end
    send_request(bswec_pkg::KIND_ADD, 32'h1234_5678, 1'b0);
    send_request(bswec_pkg::KIND_ADD, VALUE_MAX, 1'b0);
    send_request(bswec_pkg::KIND_REMOVE, VALUE_MIN, 1'b0);
    send_request(bswec_pkg::KIND_REMOVE, fill_value, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) begin
        for (k = 0; k < POOL_SIZE; k++) value_pool[k] = bswec_pkg::value_t'($urandom);
      end
      send_request(pick_kind((n / 100) % 2 == 0), pick_value(), (n / 150) % 5 == 3);
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d hits, %0d adds refused when full",
             sb.requests, sb.checked, sb.hits, sb.drops);
    $display("summary: peak set size %0d of %0d, %0d mismatches", sb.peak, CAPACITY, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/bswec_pkg.sv
rtl/core/bounded_set_with_even_count.sv
verif/tb_top.sv
